>>> rtl/wsp_pkg.sv
`timescale 1ns / 1ps
package wsp_pkg;
	localparam int FRAC_BITS = 16;
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd1;
	localparam logic MODE_LOAD    = 1'b0;
	localparam logic MODE_PROJECT = 1'b1;
	localparam logic [15:0] WIDTH_RST  = 16'd640;
	localparam logic [15:0] HEIGHT_RST = 16'd480;
	// quotient bits kept before saturation
	localparam int QB = 33;
	// divider stages: abs, scale, range check, QB steps, saturate
	localparam int DIV_LAT = QB + 4;
	localparam int IN_W  = 136;
	localparam int OUT_W = 64;
endpackage

>>> rtl/wsp_mac.sv
`timescale 1ns / 1ps
module wsp_mac #(
	parameter int FRAC_BITS = wsp_pkg::FRAC_BITS,
	localparam int PB = 64 - FRAC_BITS,
	localparam int PW = PB + 2
) (
	input  logic                 clk,
	input  logic                 en,
	input  logic signed [31:0]   c0,
	input  logic signed [31:0]   c1,
	input  logic signed [31:0]   c2,
	input  logic signed [31:0]   c3,
	input  logic signed [31:0]   x,
	input  logic signed [31:0]   y,
	input  logic signed [31:0]   z,
	output logic signed [PW-1:0] sum
);
	logic signed [63:0] m0, m1, m2, h0, h1, h2;
	logic signed [PB-1:0] p0_s1, p1_s1, p2_s1;
	logic signed [31:0] c3_s1;
	logic signed [PW-1:0] sum_s2;

	assign m0 = c0 * x;
	assign m1 = c1 * y;
	assign m2 = c2 * z;
	// arithmetic shift rounds down
	assign h0 = m0 >>> FRAC_BITS;
	assign h1 = m1 >>> FRAC_BITS;
	assign h2 = m2 >>> FRAC_BITS;

	always_ff @(posedge clk) begin
		if (en) begin
			p0_s1  <= h0[PB-1:0];
			p1_s1  <= h1[PB-1:0];
			p2_s1  <= h2[PB-1:0];
			c3_s1  <= c3;
			sum_s2 <= PW'(p0_s1) + PW'(p1_s1) + PW'(p2_s1) + PW'(c3_s1);
		end
	end

	assign sum = sum_s2;
endmodule

>>> rtl/wsp_div.sv
`timescale 1ns / 1ps
module wsp_div #(
	parameter int FRAC_BITS = wsp_pkg::FRAC_BITS,
	localparam int PW = 66 - FRAC_BITS,
	localparam int AW = PW + 1,
	localparam int RW = AW + 1,
	localparam int NW = AW + 16 + FRAC_BITS
) (
	input  logic                 clk,
	input  logic                 en,
	input  logic signed [AW-1:0] num,
	input  logic [AW-1:0]        den,
	input  logic [15:0]          scale,
	output logic signed [31:0]   res
);
	localparam int QB = wsp_pkg::QB;

	logic [AW-1:0] mag_s1, den_s1, den_s2;
	logic neg_s1, neg_s2;
	logic [15:0] scale_s1;
	logic [AW+15:0] prod_s2;
	logic [NW-1:0] p;

	logic [RW-1:0] rem_sd [QB+1];
	logic [QB-1:0] q_sd   [QB+1];
	logic [QB-1:0] lo_sd  [QB+1];
	logic [AW-1:0] den_sd [QB+1];
	logic          ovf_sd [QB+1];
	logic          neg_sd [QB+1];

	logic [QB:0] mag_n;
	logic signed [31:0] res_q;

	always_ff @(posedge clk) begin
		if (en) begin
			neg_s1   <= num[AW-1];
			mag_s1   <= num[AW-1] ? AW'(-num) : AW'(num);
			den_s1   <= den;
			scale_s1 <= scale;
			prod_s2  <= (AW+16)'(mag_s1) * (AW+16)'(scale_s1);
			den_s2   <= den_s1;
			neg_s2   <= neg_s1;
		end
	end

	assign p = {prod_s2, {FRAC_BITS{1'b0}}};

	always_ff @(posedge clk) begin
		if (en) begin
			ovf_sd[0] <= (p >> QB) >= NW'(den_s2);
			rem_sd[0] <= RW'(p >> QB);
			lo_sd[0]  <= p[QB-1:0];
			q_sd[0]   <= '0;
			den_sd[0] <= den_s2;
			neg_sd[0] <= neg_s2;
		end
	end

	for (genvar i = 0; i < QB; i++) begin : g_step
		logic [RW-1:0] t;
		logic ge;
		assign t  = {rem_sd[i][RW-2:0], lo_sd[i][QB-1]};
		assign ge = t >= {1'b0, den_sd[i]};
		always_ff @(posedge clk) begin
			if (en) begin
				rem_sd[i+1] <= ge ? t - {1'b0, den_sd[i]} : t;
				q_sd[i+1]   <= {q_sd[i][QB-2:0], ge};
				lo_sd[i+1]  <= {lo_sd[i][QB-2:0], 1'b0};
				den_sd[i+1] <= den_sd[i];
				ovf_sd[i+1] <= ovf_sd[i];
				neg_sd[i+1] <= neg_sd[i];
			end
		end
	end

	// negative quotients round away from zero in magnitude
	assign mag_n = {1'b0, q_sd[QB]} + (QB+1)'(rem_sd[QB] != '0);

	always_ff @(posedge clk) begin
		if (en) begin
			if (neg_sd[QB]) begin
				if (ovf_sd[QB] || mag_n > (QB+1)'(34'h0_8000_0000))
					res_q <= 32'sh8000_0000;
				else
					res_q <= -$signed(mag_n[31:0]);
			end else begin
				if (ovf_sd[QB] || q_sd[QB][QB-1] || q_sd[QB][31])
					res_q <= 32'sh7FFF_FFFF;
				else
					res_q <= $signed(q_sd[QB][31:0]);
			end
		end
	end

	assign res = res_q;
endmodule

>>> rtl/world_to_screen_projection.sv
`timescale 1ns / 1ps
// channel | dir | handshake          | payload
// s_*     | in  | s_tvalid/s_tready  | tuser mode; tdata index, coeff, x, y, z
// m_*     | out | m_tvalid/m_tready  | tuser visible; tdata screen_x, screen_y
// cfg_*   | in  | cfg_valid/cfg_ready| cfg_index, cfg_data
// One transaction per cycle while the output is not stalled; a project transaction's result
// passes 3 clip stages, then 37 divider stages (33 of them one quotient bit each).
// Load transactions write the matrix on acceptance and give no result.
// Reset clears valid bits and written mask and sets the viewport size to 640x480; the matrix is not reset.
// A held result stalls the whole pipeline; s_tready is low only then.
module world_to_screen_projection #(
	parameter int FRAC_BITS = wsp_pkg::FRAC_BITS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic                          s_tuser,  // mode
	input  logic [wsp_pkg::IN_W-1:0]      s_tdata,  // coeff_index, coeff_value, world_x, y, z
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic                          m_tuser,  // visible
	output logic [wsp_pkg::OUT_W-1:0]     m_tdata,  // screen_x, screen_y
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [wsp_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [15:0]                   cfg_data
);
	localparam int PW = 66 - FRAC_BITS;
	localparam int AW = PW + 1;
	localparam int DL = wsp_pkg::DIV_LAT;
	localparam logic signed [PW-1:0] WMIN = PW'(((64'd1 << FRAC_BITS) + 64'd5000) / 64'd10000);

	logic en, acc;
	logic [3:0] idx;
	logic signed [31:0] cval, wx, wy, wz;
	logic [31:0] mat_q [16];
	logic [15:0] mask_q, width_q, height_q;
	logic v_s1, v_s2, v_s3, full_s1, full_s2, vis_s3;
	logic signed [PW-1:0] cx, cy, cw;
	logic signed [AW-1:0] nx_s3, ny_s3;
	logic [AW-1:0] den_s3;
	logic signed [31:0] sx, sy;
	logic vl_q [DL];
	logic visl_q [DL];

	assign en       = !m_tvalid || m_tready;
	assign s_tready = en;
	assign acc      = s_tvalid && en;
	assign idx      = s_tdata[3:0];
	assign cval     = s_tdata[35:4];
	assign wx       = s_tdata[67:36];
	assign wy       = s_tdata[99:68];
	assign wz       = s_tdata[131:100];
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk) begin
		if (acc && s_tuser == wsp_pkg::MODE_LOAD) mat_q[idx] <= cval;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q   <= '0;
			width_q  <= wsp_pkg::WIDTH_RST;
			height_q <= wsp_pkg::HEIGHT_RST;
		end else begin
			if (acc && s_tuser == wsp_pkg::MODE_LOAD) mask_q[idx] <= 1'b1;
			if (cfg_valid) begin
				unique case (cfg_index)
					wsp_pkg::CFG_WIDTH:  width_q  <= cfg_data;
					wsp_pkg::CFG_HEIGHT: height_q <= cfg_data;
					default: ;
				endcase
			end
		end
	end

	wsp_mac #(.FRAC_BITS(FRAC_BITS)) u_mac_x (
		.clk(clk), .en(en), .c0(mat_q[0]), .c1(mat_q[4]), .c2(mat_q[8]), .c3(mat_q[12]),
		.x(wx), .y(wy), .z(wz), .sum(cx)
	);
	wsp_mac #(.FRAC_BITS(FRAC_BITS)) u_mac_y (
		.clk(clk), .en(en), .c0(mat_q[1]), .c1(mat_q[5]), .c2(mat_q[9]), .c3(mat_q[13]),
		.x(wx), .y(wy), .z(wz), .sum(cy)
	);
	wsp_mac #(.FRAC_BITS(FRAC_BITS)) u_mac_w (
		.clk(clk), .en(en), .c0(mat_q[3]), .c1(mat_q[7]), .c2(mat_q[11]), .c3(mat_q[15]),
		.x(wx), .y(wy), .z(wz), .sum(cw)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			full_s1 <= &mask_q;
			full_s2 <= full_s1;
			nx_s3   <= AW'(cx) + AW'(cw);
			ny_s3   <= AW'(cw) - AW'(cy);
			den_s3  <= {cw, 1'b0};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
			v_s3   <= 1'b0;
			vis_s3 <= 1'b0;
		end else if (en) begin
			v_s1   <= acc && s_tuser == wsp_pkg::MODE_PROJECT;
			v_s2   <= v_s1;
			v_s3   <= v_s2;
			vis_s3 <= full_s2 && cw > WMIN;
		end
	end

	wsp_div #(.FRAC_BITS(FRAC_BITS)) u_div_x (
		.clk(clk), .en(en), .num(nx_s3), .den(den_s3), .scale(width_q), .res(sx)
	);
	wsp_div #(.FRAC_BITS(FRAC_BITS)) u_div_y (
		.clk(clk), .en(en), .num(ny_s3), .den(den_s3), .scale(height_q), .res(sy)
	);

	for (genvar i = 0; i < DL; i++) begin : g_line
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vl_q[i]   <= 1'b0;
				visl_q[i] <= 1'b0;
			end else if (en) begin
				vl_q[i]   <= (i == 0) ? v_s3   : vl_q[(i == 0) ? 0 : i-1];
				visl_q[i] <= (i == 0) ? vis_s3 : visl_q[(i == 0) ? 0 : i-1];
			end
		end
	end

	assign m_tvalid = vl_q[DL-1];
	assign m_tuser  = visl_q[DL-1];
	assign m_tdata  = visl_q[DL-1] ? {sy, sx} : '0;
endmodule

>>> rtl/wsp_chk.sv
`timescale 1ns / 1ps
module wsp_chk (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          s_tready,
	input logic                          m_tvalid,
	input logic                          m_tready,
	input logic                          m_tuser,
	input logic [wsp_pkg::OUT_W-1:0]     m_tdata
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	a_hidden_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tdata == '0)
		else $error("hidden point with non-zero coordinates");

	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready == (!m_tvalid || m_tready))
		else $error("input ready does not follow output stall");
endmodule

bind world_to_screen_projection wsp_chk u_chk (.*);

>>> dv/world_to_screen_projection_test.sv
`timescale 1ns / 1ps
module world_to_screen_projection_test;
	localparam int LIMIT = 400000;
	localparam longint W_MIN = ((64'd1 << wsp_pkg::FRAC_BITS) + 5000) / 10000;

	typedef struct packed {
		logic        visible;
		logic [31:0] sx;
		logic [31:0] sy;
	} pixel_t;

	logic clk;
	logic arst_n;
	logic s_tvalid;
	logic s_tready;
	logic s_tuser;
	logic [wsp_pkg::IN_W-1:0] s_tdata;
	logic m_tvalid;
	logic m_tready;
	logic m_tuser;
	logic [wsp_pkg::OUT_W-1:0] m_tdata;
	logic cfg_valid;
	logic cfg_ready;
	logic [wsp_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [15:0] cfg_data;

	world_to_screen_projection uut (.*);

	logic [31:0] coeffs [16];
	logic [15:0] loaded_mask;
	logic [15:0] vp_width;
	logic [15:0] vp_height;
	pixel_t pending_pixels [$];
	int errors = 0;
	int cycles = 0;
	bit tx_idle_on;
	bit rx_idle_on;
	bit rx_hold;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	function automatic longint floor_shr(longint v);
		return v >>> wsp_pkg::FRAC_BITS;
	endfunction

	function automatic longint fx_mul(logic [31:0] c, longint p);
		longint cs;
		cs = longint'(signed'(c));
		return floor_shr(cs * p);
	endfunction

	// floor(num * k / den) saturated to 32 bits; wide arithmetic avoids overflow
	function automatic logic [31:0] pixel_div(longint num, longint k, longint den);
		logic signed [127:0] p;
		logic signed [127:0] q;
		logic signed [127:0] r;
		if (k == 0) return 32'd0;
		p = 128'(num) * 128'(k);
		q = p / 128'(den);
		r = p % 128'(den);
		if (r != 0 && p < 0) q = q - 1;
		if (q > 128'sd2147483647) return 32'h7fffffff;
		if (q < -128'sd2147483648) return 32'h80000000;
		return q[31:0];
	endfunction

	function automatic pixel_t project_point(logic [31:0] wx, logic [31:0] wy, logic [31:0] wz);
		pixel_t res;
		longint x;
		longint y;
		longint z;
		longint cx;
		longint cy;
		longint cw;
		res = '0;
		x = longint'(signed'(wx));
		y = longint'(signed'(wy));
		z = longint'(signed'(wz));
		if (loaded_mask == 16'hffff) begin
			cx = fx_mul(coeffs[0], x) + fx_mul(coeffs[4], y) + fx_mul(coeffs[8], z)
				+ longint'(signed'(coeffs[12]));
			cy = fx_mul(coeffs[1], x) + fx_mul(coeffs[5], y) + fx_mul(coeffs[9], z)
				+ longint'(signed'(coeffs[13]));
			cw = fx_mul(coeffs[3], x) + fx_mul(coeffs[7], y) + fx_mul(coeffs[11], z)
				+ longint'(signed'(coeffs[15]));
			if (cw > W_MIN) begin
				res.visible = 1'b1;
				res.sx = pixel_div(cx + cw, longint'(vp_width) << wsp_pkg::FRAC_BITS, 2 * cw);
				res.sy = pixel_div(cw - cy, longint'(vp_height) << wsp_pkg::FRAC_BITS, 2 * cw);
			end
		end
		return res;
	endfunction

	task automatic send_item(logic mode, logic [3:0] idx, logic [31:0] val,
			logic [31:0] wx, logic [31:0] wy, logic [31:0] wz);
		int gap;
		if (tx_idle_on && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 18);
			repeat (gap) @(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tuser = mode;
		s_tdata = {4'd0, wz, wy, wx, val, idx};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		if (mode == wsp_pkg::MODE_LOAD) begin
			coeffs[idx] = val;
			loaded_mask[idx] = 1'b1;
		end else begin
			pending_pixels.push_back(project_point(wx, wy, wz));
		end
		@(negedge clk);
		s_tvalid = 1'b0;
	endtask

	task automatic load_coeff(logic [3:0] idx, logic [31:0] val);
		send_item(wsp_pkg::MODE_LOAD, idx, val, $urandom, $urandom, $urandom);
	endtask

	task automatic project(logic [31:0] wx, logic [31:0] wy, logic [31:0] wz);
		send_item(wsp_pkg::MODE_PROJECT, 4'($urandom), $urandom, wx, wy, wz);
	endtask

	task automatic drain();
		while (pending_pixels.size() != 0) @(negedge clk);
		repeat (wsp_pkg::DIV_LAT + 10) @(negedge clk);
	endtask

	task automatic write_reg(logic [wsp_pkg::CFG_IDX_W-1:0] idx, logic [15:0] val);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		if (idx == wsp_pkg::CFG_WIDTH) vp_width = val;
		else if (idx == wsp_pkg::CFG_HEIGHT) vp_height = val;
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	function automatic logic [31:0] rand_coeff();
		case ($urandom_range(0, 3))
			0: return $urandom;
			1: return $urandom_range(0, 32'h0002_0000) - 32'h0001_0000;
			2: return 32'h0001_0000;
			default: return $urandom_range(0, 32'h0000_0fff) - 32'h0000_0800;
		endcase
	endfunction

	function automatic logic [31:0] rand_coord();
		case ($urandom_range(0, 3))
			0: return $urandom;
			1: return $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
			default: return $urandom_range(0, 32'h0400_0000) - 32'h0200_0000;
		endcase
	endfunction

	// sensible perspective matrix with w = -z plus random noise
	task automatic load_camera();
		int order [16];
		int i;
		int j;
		int t;
		for (i = 0; i < 16; i++) order[i] = i;
		for (i = 15; i > 0; i--) begin
			j = $urandom_range(0, i);
			t = order[i];
			order[i] = order[j];
			order[j] = t;
		end
		for (i = 0; i < 16; i++) begin
			case (order[i])
				0, 5: load_coeff(4'(order[i]), $urandom_range(32'h8000, 32'h30000));
				11: load_coeff(4'(order[i]), 32'hffff_0000);
				15: load_coeff(4'(order[i]), $urandom_range(0, 32'h20000));
				3, 7: load_coeff(4'(order[i]), $urandom_range(0, 32'h400) - 32'h200);
				default: load_coeff(4'(order[i]), $urandom_range(0, 32'h2000) - 32'h1000);
			endcase
		end
	endtask

	task automatic test_incomplete_matrix();
		project(32'h0001_0000, 32'h0001_0000, 32'hfffe_0000);
		for (int i = 0; i < 15; i++) load_coeff(4'(i), 32'h0001_0000);
		project(32'h0001_0000, 32'h0001_0000, 32'hfffe_0000);
		load_coeff(15, 32'h0);
		load_coeff(15, 32'h0002_0000);
	endtask

	task automatic test_directed_points();
		load_coeff(3, 32'h0);
		load_coeff(7, 32'h0);
		load_coeff(11, 32'h0);
		load_coeff(15, 32'h0001_0000);
		project(32'h0, 32'h0, 32'h0);
		project(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff);
		project(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000);
		project(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
		load_coeff(15, 32'd7);
		project(32'h0, 32'h0, 32'h0);
		load_coeff(15, 32'd8);
		project(32'h0, 32'h0, 32'h0);
		load_coeff(15, 32'h8000_0000);
		project(32'h1234_5678, 32'h0, 32'h0);
		load_coeff(15, 32'h7fff_ffff);
		project(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
		project(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
		drain();
	endtask

	task automatic test_viewport_sizes();
		logic [15:0] sizes [4] = '{16'd1, 16'hffff, 16'd0, 16'd1920};
		for (int s = 0; s < 4; s++) begin
			write_reg(wsp_pkg::CFG_WIDTH, sizes[s]);
			write_reg(wsp_pkg::CFG_HEIGHT, sizes[3 - s]);
			write_reg(2'd3, 16'($urandom));
			load_camera();
			repeat (20) project(rand_coord(), rand_coord(), rand_coord());
			drain();
		end
	endtask

	task automatic test_random_stream(int n);
		int i;
		for (i = 0; i < n; i++) begin
			if ($urandom_range(0, 99) == 0) load_camera();
			else if ($urandom_range(0, 9) == 0) load_coeff(4'($urandom), rand_coeff());
			else project(rand_coord(), rand_coord(), rand_coord());
		end
	endtask

	task automatic test_backpressure();
		rx_hold = 1'b1;
		tx_idle_on = 1'b0;
		repeat (120) project(rand_coord(), rand_coord(), rand_coord());
		drain();
	endtask

	always @(posedge clk) begin
		pixel_t got;
		pixel_t want;
		if (m_tvalid && m_tready) begin
			got = {m_tuser, m_tdata[31:0], m_tdata[63:32]};
			if (pending_pixels.size() == 0) begin
				errors++;
				if (errors <= 10) $display("unexpected result %h", got);
			end else begin
				want = pending_pixels.pop_front();
				if (got !== want) begin
					errors++;
					if (errors <= 10)
						$display("mismatch: exp vis %b x %h y %h, got vis %b x %h y %h",
							want.visible, want.sx, want.sy, got.visible, got.sx, got.sy);
				end
			end
		end
	end

	initial begin
		int stall;
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (rx_hold) begin
				m_tready <= 1'b0;
				repeat (300) @(negedge clk);
				rx_hold = 1'b0;
			end else if (rx_idle_on && $urandom_range(0, 5) == 0) begin
				m_tready <= 1'b0;
				stall = $urandom_range(1, 18);
				repeat (stall - 1) @(negedge clk);
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tuser = 1'b0;
		s_tdata = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		coeffs = '{default: '0};
		loaded_mask = '0;
		vp_width = wsp_pkg::WIDTH_RST;
		vp_height = wsp_pkg::HEIGHT_RST;
		tx_idle_on = 1'b1;
		rx_idle_on = 1'b1;
		rx_hold = 1'b0;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_incomplete_matrix();
		test_directed_points();
		test_viewport_sizes();
		write_reg(wsp_pkg::CFG_WIDTH, 16'd640);
		write_reg(wsp_pkg::CFG_HEIGHT, 16'd480);
		load_camera();
		test_random_stream(750);
		test_backpressure();
		tx_idle_on = 1'b1;
		test_random_stream(400);
		tx_idle_on = 1'b0;
		rx_idle_on = 1'b0;
		test_random_stream(200);
		drain();
		if (errors == 0 && pending_pixels.size() == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end
endmodule
